// ===== src/rtds_pkg.sv =====
`default_nettype none
package rtds_pkg;

    // field widths
    localparam int RAW_W = 63;
    localparam int NUM_W = 31;
    localparam int DEN_W = 31;
    // full-width product: 63-bit operand times 31-bit operand
    localparam int ACC_W = RAW_W + NUM_W;
    localparam int CNT_W = 6;

    // last step index of each iterative phase
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(RAW_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(NUM_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RAW,
        ST_MUL_FRAC,
        ST_DIV_PROD,
        ST_MUL_WHOLE,
        ST_DONE
    } rtds_state_t;

endpackage
`default_nettype wire

// ===== src/rational_time_delta_scaler.sv =====
`default_nettype none
// Sequence per item: 63 divide steps on raw_delta, 31 multiply steps on the fraction, 63 divide
// steps on the product, 31 multiply steps on the whole part, then the output is loaded; a zero
// denominator goes straight to the output load. Items do not overlap: s_ready is high only while
// the sequencer is idle, and every step uses the single shared 94-bit adder under the sequencer.
// Reset: synchronous active-low aresetn clears the sequencer, output valid and the carried
// remainder and applied scale to zero.
module rational_time_delta_scaler (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [rtds_pkg::RAW_W-1:0]  s_raw_delta,
    input  wire  [rtds_pkg::NUM_W-1:0]  s_scale_numerator,
    input  wire  [rtds_pkg::DEN_W-1:0]  s_scale_denominator,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [rtds_pkg::RAW_W-1:0]  m_scaled_delta,
    output logic                        m_overflow_error
);
    import rtds_pkg::*;

    rtds_state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RAW_W-1:0] dq_reg, dq_next;       // dividend in, quotient out
    logic [DEN_W-1:0] r_reg, r_next;         // partial remainder
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] mcand_reg, mcand_next;
    logic [NUM_W-1:0] mplier_reg, mplier_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_in_reg, rem_in_next;
    logic [RAW_W-1:0] whole_reg, whole_next;
    logic [DEN_W-1:0] rem_out_reg, rem_out_next;
    logic             den_zero_reg, den_zero_next;

    logic [DEN_W-1:0] carry_rem_reg, carry_rem_next;
    logic [NUM_W-1:0] app_num_reg, app_num_next;
    logic [DEN_W-1:0] app_den_reg, app_den_next;

    logic             out_valid_reg, out_valid_next;
    logic [RAW_W-1:0] out_delta_reg, out_delta_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             accept;
    logic             in_div;
    logic             load_out;
    logic [DEN_W:0]   r_shift;
    logic [ACC_W-1:0] add_a, add_b;
    logic             add_cin;
    logic [ACC_W:0]   add_sum;
    logic             div_ge;
    logic [DEN_W-1:0] div_rem;
    logic [RAW_W-1:0] div_quo;
    logic [ACC_W-1:0] mul_acc;
    logic             result_ovf;

    assign accept   = s_valid && s_ready;
    assign in_div   = (state_reg == ST_DIV_RAW) || (state_reg == ST_DIV_PROD);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    // shared adder: restoring-divide trial subtract or multiply accumulate
    assign r_shift = {r_reg, dq_reg[RAW_W-1]};
    always_comb begin
        if (in_div) begin
            add_a   = {{(ACC_W-DEN_W-1){1'b0}}, r_shift};
            add_b   = ~{{(ACC_W-DEN_W){1'b0}}, den_reg};
            add_cin = 1'b1;
        end else begin
            add_a   = acc_reg;
            add_b   = mplier_reg[0] ? mcand_reg : '0;
            add_cin = 1'b0;
        end
    end
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{ACC_W{1'b0}}, add_cin};

    // one divide step and one multiply step from the adder
    assign div_ge  = add_sum[ACC_W];
    assign div_rem = div_ge ? add_sum[DEN_W-1:0] : r_shift[DEN_W-1:0];
    assign div_quo = {dq_reg[RAW_W-2:0], div_ge};
    assign mul_acc = add_sum[ACC_W-1:0];

    assign result_ovf = den_zero_reg || (|acc_reg[ACC_W-1:RAW_W]);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_scale_denominator == '0) ? ST_DONE : ST_DIV_RAW;
                end
            end
            ST_DIV_RAW: begin
                if (cnt_reg == DIV_LAST) state_next = ST_MUL_FRAC;
            end
            ST_MUL_FRAC: begin
                if (cnt_reg == MUL_LAST) state_next = ST_DIV_PROD;
            end
            ST_DIV_PROD: begin
                if (cnt_reg == DIV_LAST) state_next = ST_MUL_WHOLE;
            end
            ST_MUL_WHOLE: begin
                if (cnt_reg == MUL_LAST) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next       = cnt_reg;
        dq_next        = dq_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_in_next    = rem_in_reg;
        whole_next     = whole_reg;
        rem_out_next   = rem_out_reg;
        den_zero_next  = den_zero_reg;
        carry_rem_next = carry_rem_reg;
        app_num_next   = app_num_reg;
        app_den_next   = app_den_reg;
        out_valid_next = out_valid_reg;
        out_delta_next = out_delta_reg;
        out_ovf_next   = out_ovf_reg;

        // drop the output item once taken
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    num_next      = s_scale_numerator;
                    den_next      = s_scale_denominator;
                    dq_next       = s_raw_delta;
                    r_next        = '0;
                    cnt_next      = '0;
                    den_zero_next = (s_scale_denominator == '0);
                    // clear the carry on a scale change or a stale remainder
                    if ((s_scale_numerator != app_num_reg) ||
                        (s_scale_denominator != app_den_reg) ||
                        (carry_rem_reg >= s_scale_denominator)) begin
                        rem_in_next = '0;
                    end else begin
                        rem_in_next = carry_rem_reg;
                    end
                end
            end
            ST_DIV_RAW: begin
                dq_next  = div_quo;
                r_next   = div_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    // whole part kept, fraction times numerator plus carry next
                    whole_next  = div_quo;
                    acc_next    = {{(ACC_W-DEN_W){1'b0}}, rem_in_reg};
                    mcand_next  = {{(ACC_W-DEN_W){1'b0}}, div_rem};
                    mplier_next = num_reg;
                    cnt_next    = '0;
                end
            end
            ST_MUL_FRAC: begin
                acc_next    = mul_acc;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[NUM_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    // product stays below 2^63
                    dq_next  = mul_acc[RAW_W-1:0];
                    r_next   = '0;
                    cnt_next = '0;
                end
            end
            ST_DIV_PROD: begin
                dq_next  = div_quo;
                r_next   = div_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    rem_out_next = div_rem;
                    acc_next     = {{(ACC_W-RAW_W){1'b0}}, div_quo};
                    mcand_next   = {{(ACC_W-RAW_W){1'b0}}, whole_reg};
                    mplier_next  = num_reg;
                    cnt_next     = '0;
                end
            end
            ST_MUL_WHOLE: begin
                acc_next    = mul_acc;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[NUM_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
            end
            ST_DONE: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    out_ovf_next   = result_ovf;
                    out_delta_next = result_ovf ? '0 : acc_reg[RAW_W-1:0];
                    // commit state only on success
                    if (!result_ovf) begin
                        carry_rem_next = rem_out_reg;
                        app_num_next   = num_reg;
                        app_den_next   = den_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            carry_rem_reg <= '0;
            app_num_reg   <= '0;
            app_den_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            carry_rem_reg <= carry_rem_next;
            app_num_reg   <= app_num_next;
            app_den_reg   <= app_den_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        dq_reg        <= dq_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        rem_in_reg    <= rem_in_next;
        whole_reg     <= whole_next;
        rem_out_reg   <= rem_out_next;
        den_zero_reg  <= den_zero_next;
        out_delta_reg <= out_delta_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = out_valid_reg;
    assign m_scaled_delta   = out_delta_reg;
    assign m_overflow_error = out_ovf_reg;

endmodule
`default_nettype wire
